[rtl/bil_pkg.sv]
// Shared types and constants for the boot image block loader.
package bil_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam logic [7:0]  SIG_VALUE       = 8'hA7;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_BADSIG = 2'd2,
    KIND_BADSUM = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] word;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

[rtl/boot_image_block_loader_unit.sv]
// Top level of the boot image block loader.
//
//   Channel  Direction  Signals                       Content
//   in_      request in in_tvalid/tready/tdata[7:0]   one image byte
//   out_     result out out_tvalid/tready/tdata/tuser word write or status
//   cfg_     write in   cfg_valid/ready/data[31:0]    ram_base
//
// Each accepted byte is processed in the cycle it is taken; its results
// enter a four-entry queue and are registered there before they appear at out_.
// A byte is taken every cycle while at least two queue entries are free.
// The last byte of the final block may give two results; the queue absorbs them.
// Reset is synchronous and active low; it clears the parser state, empties the queue and clears ram_base.
module boot_image_block_loader_unit #(
  parameter int unsigned BLOCK_BYTES = bil_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] address, [63:32] word
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]    ram_base_r;
  logic           in_fire;
  logic           space;
  bil_pkg::push_t push;
  bil_pkg::res_t  res;

  assign cfg_ready = 1'b1;
  assign in_tready = space;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ram_base_r <= cfg_data;
    end
  end

  bil_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .data_byte(in_tdata),
    .ram_base (ram_base_r),
    .push     (push)
  );

  bil_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space    (space),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {res.word, res.address};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

[rtl/bil_core.sv]
// Header parsing, word packing and checksum state for the boot image loader.
module bil_core #(
  parameter int unsigned BLOCK_BYTES = bil_pkg::BLOCK_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    data_byte,
  input  logic [31:0]   ram_base,
  output bil_pkg::push_t push
);

  localparam int unsigned PW = $clog2(BLOCK_BYTES);
  localparam logic [PW-1:0] POS_END  = PW'(BLOCK_BYTES - 1);
  localparam logic [PW-1:0] POS_SUM  = PW'(BLOCK_BYTES - 3);
  localparam logic [31:0]   BLK_SIZE = 32'(BLOCK_BYTES);

  bil_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   fsize_r, fsize_nxt;
  logic [31:0]   remain_r, remain_nxt;
  logic [23:0]   acc_r, acc_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    exp_r, exp_nxt;
  logic [7:0]    sig_r, sig_nxt;
  logic [31:0]   waddr_r, waddr_nxt;
  logic [7:0]    sum_add;
  logic          block_end;
  logic          load_end;
  bil_pkg::res_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bil_pkg::PH_HEADER;
      pos_r    <= '0;
      fsize_r  <= '0;
      remain_r <= '0;
      acc_r    <= '0;
      sum_r    <= '0;
      exp_r    <= '0;
      sig_r    <= '0;
      waddr_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      fsize_r  <= fsize_nxt;
      remain_r <= remain_nxt;
      acc_r    <= acc_nxt;
      sum_r    <= sum_nxt;
      exp_r    <= exp_nxt;
      sig_r    <= sig_nxt;
      waddr_r  <= waddr_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fsize_nxt  = fsize_r;
    remain_nxt = remain_r;
    acc_nxt    = acc_r;
    sum_nxt    = sum_r;
    exp_nxt    = exp_r;
    sig_nxt    = sig_r;
    waddr_nxt  = waddr_r;
    push       = '0;
    sum_add    = sum_r + data_byte;
    block_end  = (pos_r == POS_END);
    load_end   = block_end && (remain_r <= BLK_SIZE);
    status     = '0;
    status.last = 1'b1;
    if (in_fire) begin
      unique case (phase_r)
        bil_pkg::PH_HEADER: begin
          if (pos_r == '0) begin
            sig_nxt = data_byte;
          end
          if ((pos_r >= PW'(1)) && (pos_r <= PW'(4))) begin
            fsize_nxt = {fsize_r[23:0], data_byte};
          end
          if (block_end) begin
            exp_nxt = data_byte;
          end
          if (pos_r <= POS_SUM) begin
            sum_nxt = sum_add;
          end
          if (!block_end) begin
            pos_nxt = pos_r + PW'(1);
          end else begin
            pos_nxt = '0;
            acc_nxt = '0;
            status.word = {24'd0, sum_r};
            if (sig_r != bil_pkg::SIG_VALUE) begin
              status.kind = bil_pkg::KIND_BADSIG;
              push.r0     = status;
              push.n      = 2'd1;
              phase_nxt   = bil_pkg::PH_DONE;
            end else begin
              remain_nxt = fsize_r;
              waddr_nxt  = ram_base;
              if (fsize_r == '0) begin
                status.kind = (sum_r == data_byte) ? bil_pkg::KIND_OK : bil_pkg::KIND_BADSUM;
                push.r0     = status;
                push.n      = 2'd1;
                phase_nxt   = bil_pkg::PH_DONE;
              end else begin
                phase_nxt = bil_pkg::PH_DATA;
              end
            end
          end
        end
        bil_pkg::PH_DATA: begin
          sum_nxt = sum_add;
          acc_nxt = {acc_r[15:0], data_byte};
          if (pos_r[1:0] == 2'b11) begin
            push.r0.kind    = bil_pkg::KIND_WORD;
            push.r0.address = waddr_r;
            push.r0.word    = {acc_r, data_byte};
            push.r0.last    = !load_end;
            push.n          = 2'd1;
            waddr_nxt       = waddr_r + 32'd4;
            acc_nxt         = '0;
          end
          if (block_end) begin
            pos_nxt = '0;
            acc_nxt = '0;
            if (load_end) begin
              status.kind = (sum_add == exp_r) ? bil_pkg::KIND_OK : bil_pkg::KIND_BADSUM;
              status.word = {24'd0, sum_add};
              if (pos_r[1:0] == 2'b11) begin
                push.r1 = status;
                push.n  = 2'd2;
              end else begin
                push.r0 = status;
                push.n  = 2'd1;
              end
              phase_nxt = bil_pkg::PH_DONE;
            end else begin
              remain_nxt = remain_r - BLK_SIZE;
            end
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
        bil_pkg::PH_DONE: begin
          phase_nxt = bil_pkg::PH_DONE;
        end
        default: begin
          phase_nxt = bil_pkg::PH_DONE;
        end
      endcase
    end
  end

endmodule

[rtl/bil_outq.sv]
// Small result queue that takes up to two results per cycle and gives one.
module bil_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  bil_pkg::push_t push,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output bil_pkg::res_t  out_res
);

  localparam int unsigned AW = bil_pkg::QUEUE_AW;
  localparam int unsigned CW = AW + 1;

  bil_pkg::res_t mem_r [bil_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space     = (cnt_r <= CW'(bil_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= push.r1;
    end
  end

endmodule

[rtl/bil_chk.sv]
// Port-level checks for the boot image block loader, bound to the top level.
module bil_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic        out_fire;
  logic        is_word;
  logic        done_r;
  logic        have_prev_r;
  logic [31:0] prev_addr_r;

  assign out_fire = out_tvalid && out_tready;
  assign is_word  = (out_tuser == bil_pkg::KIND_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      have_prev_r <= 1'b0;
      prev_addr_r <= '0;
    end else begin
      if (out_fire && !is_word) begin
        done_r <= 1'b1;
      end
      if (out_fire && is_word) begin
        have_prev_r <= 1'b1;
        prev_addr_r <= out_tdata[31:0];
      end
    end
  end

  // Nothing follows the status result.
  a_quiet_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !out_tvalid)
    else $error("result after status");

  // A status result carries a zero address, an 8-bit checksum and ends the run.
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !is_word) |->
      (out_tdata[31:0] == 32'd0) && (out_tdata[63:40] == 24'd0) && out_tlast)
    else $error("malformed status result");

  // Word write addresses rise by four.
  a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && is_word && have_prev_r) |->
      (out_tdata[31:0] == prev_addr_r + 32'd4))
    else $error("word address did not step by four");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind boot_image_block_loader_unit bil_chk u_bil_chk (.*);
